// ===== rtl/tsp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsp_pkg
// shared types and constants of the tone sequence player
// ----------------------------------------------------------------------------
package tsp_pkg;

  // default number of melody entries
  localparam int unsigned DefaultTableDepth = 256;

  // width of values handed to the modulo unit
  // (start + 2*duration + depth - 2 always stays below 2**18)
  localparam int unsigned ModW = 18;

  localparam int unsigned NoteW  = 16;
  localparam int unsigned DurW   = 16;
  localparam int unsigned EntryW = NoteW + DurW;

  // item opcodes
  typedef enum logic [2:0] {
    OP_WRITE     = 3'd0,
    OP_PLAY      = 3'd1,
    OP_TICK      = 3'd2,
    OP_ALERT_ON  = 3'd3,
    OP_ALERT_OFF = 3'd4,
    OP_QUERY     = 3'd5
  } tsp_op_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_LOOP_CODE   = 2'd0,
    CFG_FINISH_CODE = 2'd1,
    CFG_ALERT_NOTE  = 2'd2,
    CFG_SILENT_NOTE = 2'd3
  } tsp_cfg_e;

  localparam logic [15:0] LoopCodeReset   = 16'd65534;
  localparam logic [15:0] FinishCodeReset = 16'd65535;
  localparam logic [15:0] AlertNoteReset  = 16'd1000;
  localparam logic [15:0] SilentNoteReset = 16'd0;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_IDXMOD,
    ST_RD1,
    ST_RD2,
    ST_LOOPMOD,
    ST_EMIT
  } tsp_state_e;

endpackage
`default_nettype wire

// ===== rtl/tone_sequence_player_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tone_sequence_player_unit
// melody player: table of (note, duration) entries stepped by tick items
// ----------------------------------------------------------------------------
// usage
// - input channel (valid/stall) carries one item per beat: write entry, play,
//   tick, alert on, alert off or query; output channel carries note beats
// - configuration writes (loop/finish code, alert/silent note) use cfg_*_i;
//   the user must make them while the block is idle; it is not enforced
// - one item is worked on at a time; the melody table is a single memory
//   with registered read data
// - alert on/off, query, play and write items need no table read; a tick
//   waits for its entry read, or two when the pointer advances; a result
//   beat is loaded into the output register at the last edge of its item
// - for a depth that is not a power of two a loop entry waits for the
//   modulo unit to wrap its target, and below 256 entries write and play
//   items wait for it to wrap the index
// - a result is registered; the next item is taken while it waits, and
//   a new result stalls the input until the receiver takes the old one
// - reset clears the player state and the output valid flag and loads the
//   configuration defaults; the table content stays undefined until written
// ----------------------------------------------------------------------------
module tone_sequence_player_unit #(
  parameter int unsigned TABLE_DEPTH = tsp_pkg::DefaultTableDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_addr_i,
  input  wire logic [15:0] cfg_wdata_i,
  // item channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  opcode_i,
  input  wire logic [7:0]  entry_index_i,
  input  wire logic [15:0] entry_note_i,
  input  wire logic [15:0] entry_duration_i,
  input  wire logic [7:0]  tick_ms_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [15:0]      note_out_o,
  output logic             alert_active_o
);
  import tsp_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam bit IsPow2    = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;
  // entry_index needs no wrap if it can't reach the depth or the depth is 2**n
  localparam bit IdxDirect = (TABLE_DEPTH >= 256) || IsPow2;

  tsp_state_e state_q, state_d;

  // item fields kept for the later cycles of an item
  logic [2:0]  op_q, op_d;
  logic [15:0] wnote_q, wnote_d;
  logic [15:0] wdur_q, wdur_d;
  logic [7:0]  tick_q, tick_d;

  // player state
  logic [AW-1:0] ptr_q, ptr_d;
  logic [AW-1:0] start_q, start_d;
  logic          playing_q, playing_d;
  logic          first_q, first_d;
  logic          alert_q, alert_d;
  logic [31:0]   elapsed_q, elapsed_d;

  // configuration registers
  logic [15:0] loop_code_q, finish_code_q, alarm_tone_q, silent_note_q;

  // result waiting for the output register
  logic [15:0] pend_note_q, pend_note_d;
  logic        pend_alert_q, pend_alert_d;

  // output register
  logic        out_valid_q, out_valid_d;
  logic [15:0] out_note_q, out_note_d;
  logic        out_alert_q, out_alert_d;

  // memory and modulo unit hookup
  logic              tbl_we, tbl_re;
  logic [AW-1:0]     tbl_waddr, tbl_raddr;
  logic [EntryW-1:0] tbl_wdata, tbl_rdata;
  logic [NoteW-1:0]  rd_note;
  logic [DurW-1:0]   rd_dur;
  logic              mod_start, mod_done;
  logic [ModW-1:0]   mod_value;
  logic [AW-1:0]     mod_rem;

  // datapath helpers
  logic [AW-1:0]   idx_direct;
  logic [AW-1:0]   ptr_inc;
  logic [32:0]     el_sum;
  logic [31:0]     el_sat;
  logic [ModW-1:0] loop_target;
  logic            out_free;

  // emission request from the current cycle
  logic        emit_req;
  logic [15:0] emit_note;
  logic        emit_alert;

  assign rd_note    = tbl_rdata[EntryW-1:DurW];
  assign rd_dur     = tbl_rdata[DurW-1:0];
  assign idx_direct = AW'(entry_index_i);
  assign ptr_inc    = (ptr_q == AW'(TABLE_DEPTH - 1)) ? '0 : ptr_q + AW'(1);
  assign el_sum     = {1'b0, elapsed_q} + 33'(tick_q);
  assign el_sat     = el_sum[32] ? '1 : el_sum[31:0];
  assign loop_target = ModW'(start_q) + ModW'({rd_dur, 1'b0}) + ModW'(TABLE_DEPTH - 2);
  // old result leaves at this edge or there is none
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    wnote_d      = wnote_q;
    wdur_d       = wdur_q;
    tick_d       = tick_q;
    ptr_d        = ptr_q;
    start_d      = start_q;
    playing_d    = playing_q;
    first_d      = first_q;
    alert_d      = alert_q;
    elapsed_d    = elapsed_q;
    pend_note_d  = pend_note_q;
    pend_alert_d = pend_alert_q;
    out_note_d   = out_note_q;
    out_alert_d  = out_alert_q;
    out_valid_d  = out_stall_i ? out_valid_q : 1'b0;
    tbl_we       = 1'b0;
    tbl_waddr    = idx_direct;
    tbl_wdata    = {entry_note_i, entry_duration_i};
    tbl_re       = 1'b0;
    tbl_raddr    = ptr_q;
    mod_start    = 1'b0;
    mod_value    = ModW'(entry_index_i);
    emit_req     = 1'b0;
    emit_note    = '0;
    emit_alert   = alert_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d    = opcode_i;
          wnote_d = entry_note_i;
          wdur_d  = entry_duration_i;
          tick_d  = tick_ms_i;
          unique case (opcode_i)
            OP_WRITE: begin
              if (IdxDirect) begin
                tbl_we = 1'b1;
              end else begin
                mod_start = 1'b1;
                state_d   = ST_IDXMOD;
              end
            end
            OP_PLAY: begin
              // ignored while alerting
              if (!alert_q) begin
                if (IdxDirect) begin
                  start_d   = idx_direct;
                  ptr_d     = idx_direct;
                  playing_d = 1'b1;
                  first_d   = 1'b1;
                end else begin
                  mod_start = 1'b1;
                  state_d   = ST_IDXMOD;
                end
              end
            end
            OP_TICK: begin
              if (!alert_q && playing_q) begin
                tbl_re  = 1'b1;
                state_d = ST_RD1;
              end
            end
            OP_ALERT_ON: begin
              alert_d    = 1'b1;
              emit_req   = 1'b1;
              emit_note  = alarm_tone_q;
              emit_alert = 1'b1;
            end
            OP_ALERT_OFF: begin
              alert_d    = 1'b0;
              emit_req   = 1'b1;
              emit_note  = silent_note_q;
              emit_alert = 1'b0;
            end
            OP_QUERY: begin
              emit_req = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_IDXMOD: begin
        if (mod_done) begin
          if (op_q == OP_WRITE) begin
            tbl_we    = 1'b1;
            tbl_waddr = mod_rem;
            tbl_wdata = {wnote_q, wdur_q};
          end else begin
            start_d   = mod_rem;
            ptr_d     = mod_rem;
            playing_d = 1'b1;
            first_d   = 1'b1;
          end
          state_d = ST_IDLE;
        end
      end
      ST_RD1: begin
        state_d = ST_IDLE;
        if (first_q) begin
          first_d   = 1'b0;
          elapsed_d = '0;
          emit_req  = 1'b1;
          emit_note = rd_note;
        end else begin
          elapsed_d = el_sat;
          if (el_sat > 32'(rd_dur)) begin
            // duration used up: step to the next entry
            ptr_d     = ptr_inc;
            tbl_re    = 1'b1;
            tbl_raddr = ptr_inc;
            state_d   = ST_RD2;
          end
        end
      end
      ST_RD2: begin
        state_d = ST_IDLE;
        if (rd_note == loop_code_q) begin
          // jump back, timer keeps running, nothing emitted
          if (IsPow2) begin
            ptr_d = AW'(loop_target);
          end else begin
            mod_start = 1'b1;
            mod_value = loop_target;
            state_d   = ST_LOOPMOD;
          end
        end else if (rd_note == finish_code_q) begin
          playing_d = 1'b0;
          emit_req  = 1'b1;
          emit_note = rd_note;
        end else begin
          elapsed_d = '0;
          emit_req  = 1'b1;
          emit_note = rd_note;
        end
      end
      ST_LOOPMOD: begin
        if (mod_done) begin
          ptr_d   = mod_rem;
          state_d = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_note_d  = pend_note_q;
          out_alert_d = pend_alert_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // a new result goes straight out or waits for the receiver
    if (emit_req) begin
      if (out_free) begin
        out_valid_d = 1'b1;
        out_note_d  = emit_note;
        out_alert_d = emit_alert;
        state_d     = ST_IDLE;
      end else begin
        pend_note_d  = emit_note;
        pend_alert_d = emit_alert;
        state_d      = ST_EMIT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ptr_q       <= '0;
      start_q     <= '0;
      playing_q   <= 1'b0;
      first_q     <= 1'b0;
      alert_q     <= 1'b0;
      elapsed_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      start_q     <= start_d;
      playing_q   <= playing_d;
      first_q     <= first_d;
      alert_q     <= alert_d;
      elapsed_q   <= elapsed_d;
      out_valid_q <= out_valid_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loop_code_q   <= LoopCodeReset;
      finish_code_q <= FinishCodeReset;
      alarm_tone_q  <= AlertNoteReset;
      silent_note_q <= SilentNoteReset;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_LOOP_CODE:   loop_code_q   <= cfg_wdata_i;
        CFG_FINISH_CODE: finish_code_q <= cfg_wdata_i;
        CFG_ALERT_NOTE:  alarm_tone_q  <= cfg_wdata_i;
        CFG_SILENT_NOTE: silent_note_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    wnote_q      <= wnote_d;
    wdur_q       <= wdur_d;
    tick_q       <= tick_d;
    pend_note_q  <= pend_note_d;
    pend_alert_q <= pend_alert_d;
    out_note_q   <= out_note_d;
    out_alert_q  <= out_alert_d;
  end

  // melody memory, only touched from one state at a time so no
  // write and read of the same entry overlap
  tsp_table #(
    .Depth (TABLE_DEPTH),
    .W     (EntryW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .re_i    (tbl_re),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  // wrap of indexes and loop targets for a depth that isn't a power of two
  tsp_mod #(
    .Depth (TABLE_DEPTH)
  ) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .value_i (mod_value),
    .done_o  (mod_done),
    .rem_o   (mod_rem)
  );

  assign out_valid_o    = out_valid_q;
  assign note_out_o     = out_note_q;
  assign alert_active_o = out_alert_q;

endmodule
`default_nettype wire

// ===== rtl/tsp_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsp_table
// melody memory: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module tsp_table #(
  parameter int unsigned Depth = tsp_pkg::DefaultTableDepth,
  parameter int unsigned W     = tsp_pkg::EntryW
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [W-1:0]             wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [W-1:0]             rdata_o
);
  import tsp_pkg::*;

  logic [W-1:0] mem_q [Depth];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/tsp_mod.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsp_mod
// remainder by the table depth: reciprocal multiply, back multiply and one
// correcting subtract; value, quotient and raw remainder are registered in
// turn, and done_o is raised together with the remainder register
module tsp_mod #(
  parameter int unsigned Depth = tsp_pkg::DefaultTableDepth
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic [tsp_pkg::ModW-1:0] value_i,
  output logic                          done_o,
  output logic      [$clog2(Depth)-1:0] rem_o
);
  import tsp_pkg::*;

  localparam int unsigned AW = $clog2(Depth);
  // reciprocal of the depth scaled by 2**ModW, rounded down
  localparam logic [ModW-1:0] Recip  = ModW'((64'd1 << ModW) / Depth);
  localparam logic [ModW-1:0] DepthV = ModW'(Depth);

  logic              st1_q, st2_q, done_q;
  logic [ModW-1:0]   val_q, quot_q, rem_q;
  logic [2*ModW-1:0] prod;
  logic [ModW-1:0]   back;
  logic [ModW-1:0]   rem_fix;

  // quotient estimate is low by at most one, so the remainder is below 2*depth
  assign prod    = {{ModW{1'b0}}, val_q} * {{ModW{1'b0}}, Recip};
  assign back    = ModW'(quot_q * DepthV);
  assign rem_fix = (rem_q >= DepthV) ? rem_q - DepthV : rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st1_q  <= 1'b0;
      st2_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      st1_q  <= start_i;
      st2_q  <= st1_q;
      done_q <= st2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q <= value_i;
    end
    if (st1_q) begin
      quot_q <= prod[2*ModW-1:ModW];
    end
    if (st2_q) begin
      rem_q <= val_q - back;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_fix[AW-1:0];

endmodule
`default_nettype wire

// ===== rtl/tsp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsp_checker
// port level checks of the tone sequence player
// ----------------------------------------------------------------------------
module tsp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic [2:0]  opcode_i,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [15:0] note_out_o,
  input wire logic        alert_active_o
);
  import tsp_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(note_out_o)
      && $stable(alert_active_o))
    else $error("result beat changed while stalled");

  // alert on shows up at once with the flag set
  a_alert_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !out_valid_o && (opcode_i == OP_ALERT_ON)
      |=> out_valid_o && alert_active_o)
    else $error("alert on gave no flagged result");

  // alert off shows up at once with the flag cleared
  a_alert_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !out_valid_o && (opcode_i == OP_ALERT_OFF)
      |=> out_valid_o && !alert_active_o)
    else $error("alert off gave no cleared result");

  // query reports a zero note
  a_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !out_valid_o && (opcode_i == OP_QUERY)
      |=> out_valid_o && (note_out_o == 16'd0))
    else $error("query result wrong");

  // a table write never produces a result
  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !out_valid_o && (opcode_i == OP_WRITE) |=> !out_valid_o)
    else $error("write item produced a result");

endmodule

bind tone_sequence_player_unit tsp_checker u_tsp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .opcode_i       (opcode_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .note_out_o     (note_out_o),
  .alert_active_o (alert_active_o)
);
`default_nettype wire
